FILE: rtl/core/ssri_pkg.sv
// ----------------------------------------------------------------------------
// ssri_pkg - shared types for the sorted sparse row store
// Status codes, configuration register indexes and port field types.
// ----------------------------------------------------------------------------
package ssri_pkg;

  localparam int unsigned COL_W = 16;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ENT_W = COL_W + VAL_W;

  typedef logic [1:0]  cfg_idx_t;
  typedef logic [15:0] cfg_data_t;

  localparam cfg_idx_t CFG_ROW_COUNT    = 2'd0;
  localparam cfg_idx_t CFG_COLUMN_COUNT = 2'd1;
  localparam cfg_idx_t CFG_NO_NEW       = 2'd2;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_NO_NEW   = 3'd2,
    ST_ROW_FULL = 3'd3,
    ST_BAD_ROW  = 3'd4,
    ST_BAD_COL  = 3'd5
  } status_e;

  typedef logic [63:0] in_data_t;   // row, column, value
  typedef logic [0:0]  in_user_t;   // accumulate
  typedef logic [55:0] out_data_t;  // slot, stored_value, row_length, total_entries
  typedef logic [2:0]  out_user_t;  // status

endpackage

FILE: rtl/core/sorted_sparse_row_insert.sv
// ----------------------------------------------------------------------------
// sorted_sparse_row_insert - sparse matrix row store with sorted insert
// Keeps per-row column lists in ascending order; updates, accumulates or
// inserts one entry per input word and returns one status word.
// ----------------------------------------------------------------------------
// Each input word names a row, a column, a Q16.16 value and an accumulate
// flag. The block looks the column up in the row, then overwrites the value,
// adds to it with signed saturation, or inserts a new entry at its sorted
// position and moves the later entries of the row up by one slot. One result
// word comes back per input word. Entries live in a single entry memory of
// MAX_ROWS*ROW_CAPACITY slots and row lengths in a row-length memory, both
// with one write and one registered read port. The linear search reads the
// row's slots in turn, at most the row length, and the shift moves the later
// entries up one at a time; each makes one entry memory access per cycle.
// The slots read and the entries moved together never exceed ROW_CAPACITY.
// A new word is taken while a result still waits at the output.
// After reset a clearing pass zeroes the row lengths; no input word is
// taken during it, configuration writes are.
module sorted_sparse_row_insert #(
  parameter int unsigned MAX_ROWS     = 64,
  parameter int unsigned ROW_CAPACITY = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  ssri_pkg::cfg_idx_t    cfg_idx_i,
  input  ssri_pkg::cfg_data_t   cfg_wdata_i,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  ssri_pkg::in_data_t    s_axis_tdata,   // [15:0] row, [31:16] column, [63:32] value
  input  ssri_pkg::in_user_t    s_axis_tuser,   // [0] accumulate
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output ssri_pkg::out_data_t   m_axis_tdata,   // [3:0] slot, [35:4] stored_value,
                                                // [40:36] row_length, [51:41] total_entries
  output ssri_pkg::out_user_t   m_axis_tuser    // [2:0] status
);
  import ssri_pkg::*;

  localparam int unsigned DEPTH = MAX_ROWS * ROW_CAPACITY;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned SIW   = $clog2(ROW_CAPACITY);
  localparam int unsigned LW    = $clog2(ROW_CAPACITY + 1);
  localparam int unsigned TW    = $clog2(DEPTH + 1);

  localparam logic [LW-1:0] CAP_L = LW'(ROW_CAPACITY);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LEN, S_SRCH, S_UPD, S_MISS, S_SHIFT, S_INS, S_RESP
  } state_e;

  state_e state_q;

  // configuration registers
  logic [6:0]       row_count_q;
  logic [COL_W-1:0] column_count_q;
  logic             no_new_q;

  // current word
  logic [RW-1:0]    row_q;
  logic [AW-1:0]    base_q;
  logic [COL_W-1:0] col_q;
  logic [VAL_W-1:0] val_q;
  logic             acc_q;
  logic [LW-1:0]    len_q;
  logic [LW-1:0]    i_q;      // search position, later the insert position
  logic [LW-1:0]    sh_j_q;   // destination slot of the entry arriving from memory
  logic [VAL_W-1:0] hit_val_q;
  logic [RW-1:0]    clr_q;
  logic [TW-1:0]    total_q;

  // staged result
  status_e          res_status_q;
  logic [3:0]       res_slot_q;
  logic [VAL_W-1:0] res_val_q;
  logic [4:0]       res_len_q;

  // output register
  logic             out_valid_q;
  out_data_t        out_data_q;
  out_user_t        out_user_q;

  // memories
  logic [ENT_W-1:0] ent_mem_q [DEPTH];
  logic [ENT_W-1:0] ent_rdata_q;
  logic             ent_we, ent_re;
  logic [AW-1:0]    ent_waddr, ent_raddr;
  logic [ENT_W-1:0] ent_wdata;

  logic [LW-1:0]    len_mem_q [MAX_ROWS];
  logic [LW-1:0]    len_rdata_q;
  logic             len_we, len_re;
  logic [RW-1:0]    len_waddr, len_raddr;
  logic [LW-1:0]    len_wdata;

  // input decode
  logic             in_acc;
  logic [15:0]      in_row;
  logic             bad_row;
  logic [LW-1:0]    len_clamped;
  logic [COL_W-1:0] rd_col;
  logic [VAL_W-1:0] rd_val;
  logic [VAL_W:0]   sum;
  logic [VAL_W-1:0] sat_sum;
  logic [VAL_W-1:0] new_val;
  logic             out_free;

  assign in_acc      = s_axis_tvalid && s_axis_tready;
  assign in_row      = s_axis_tdata[15:0];
  assign bad_row     = (in_row >= {9'd0, row_count_q}) || (in_row >= 16'(MAX_ROWS));
  assign len_clamped = (len_rdata_q > CAP_L) ? CAP_L : len_rdata_q;
  assign rd_col      = ent_rdata_q[ENT_W-1:VAL_W];
  assign rd_val      = ent_rdata_q[VAL_W-1:0];
  assign out_free    = !out_valid_q || m_axis_tready;

  // saturating Q16.16 add
  assign sum     = {hit_val_q[VAL_W-1], hit_val_q} + {val_q[VAL_W-1], val_q};
  assign sat_sum = (sum[VAL_W] != sum[VAL_W-1]) ?
                   (sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}}) :
                   sum[VAL_W-1:0];
  assign new_val = acc_q ? sat_sum : val_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // memory port control
  always_comb begin
    ent_we    = 1'b0;
    ent_re    = 1'b0;
    ent_waddr = base_q;
    ent_raddr = base_q;
    ent_wdata = ent_rdata_q;
    len_we    = 1'b0;
    len_re    = 1'b0;
    len_waddr = row_q;
    len_raddr = in_row[RW-1:0];
    len_wdata = len_q + LW'(1);
    case (state_q)
      S_CLEAR: begin
        len_we    = 1'b1;
        len_waddr = clr_q;
        len_wdata = '0;
      end
      S_IDLE: begin
        len_re = in_acc && !bad_row;
      end
      S_LEN: begin
        // start the search at slot zero
        ent_re = (col_q < column_count_q) && (len_clamped != '0);
      end
      S_SRCH: begin
        // fetch the next slot while comparing this one
        ent_re    = (rd_col < col_q) && (i_q + LW'(1) != len_q);
        ent_raddr = base_q + AW'(SIW'(i_q + LW'(1)));
      end
      S_UPD: begin
        ent_we    = 1'b1;
        ent_waddr = base_q + AW'(i_q[SIW-1:0]);
        ent_wdata = {col_q, new_val};
      end
      S_MISS: begin
        ent_re    = !no_new_q && (len_q != CAP_L) && (len_q != i_q);
        ent_raddr = base_q + AW'(SIW'(len_q - LW'(1)));
      end
      S_SHIFT: begin
        // move one entry up, fetch the one below it
        ent_we    = 1'b1;
        ent_waddr = base_q + AW'(sh_j_q[SIW-1:0]);
        ent_wdata = ent_rdata_q;
        ent_re    = (sh_j_q - LW'(1) != i_q);
        ent_raddr = base_q + AW'(SIW'(sh_j_q - LW'(2)));
      end
      S_INS: begin
        ent_we    = 1'b1;
        ent_waddr = base_q + AW'(i_q[SIW-1:0]);
        ent_wdata = {col_q, val_q};
        len_we    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem_q[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rdata_q <= ent_mem_q[ent_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem_q[len_waddr] <= len_wdata;
    end
    if (len_re) begin
      len_rdata_q <= len_mem_q[len_raddr];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= 7'd64;
      column_count_q <= 16'hFFFF;
      no_new_q       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROW_COUNT:    row_count_q    <= cfg_wdata_i[6:0];
        CFG_COLUMN_COUNT: column_count_q <= cfg_wdata_i;
        CFG_NO_NEW:       no_new_q       <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      total_q      <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_user_q   <= '0;
      row_q        <= '0;
      base_q       <= '0;
      col_q        <= '0;
      val_q        <= '0;
      acc_q        <= 1'b0;
      len_q        <= '0;
      i_q          <= '0;
      sh_j_q       <= '0;
      hit_val_q    <= '0;
      res_status_q <= ST_UPDATED;
      res_slot_q   <= '0;
      res_val_q    <= '0;
      res_len_q    <= '0;
    end else begin
      // S_RESP reloads the output register itself when it is free
      if (m_axis_tready && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + RW'(1);
          if (clr_q == RW'(MAX_ROWS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            row_q  <= in_row[RW-1:0];
            base_q <= AW'(in_row[RW-1:0] * ROW_CAPACITY);
            col_q  <= s_axis_tdata[31:16];
            val_q  <= s_axis_tdata[63:32];
            acc_q  <= s_axis_tuser[0];
            i_q    <= '0;
            if (bad_row) begin
              res_status_q <= ST_BAD_ROW;
              res_slot_q   <= '0;
              res_val_q    <= '0;
              res_len_q    <= '0;
              state_q      <= S_RESP;
            end else begin
              state_q <= S_LEN;
            end
          end
        end
        S_LEN: begin
          len_q      <= len_clamped;
          res_len_q  <= 5'(len_clamped);
          res_slot_q <= '0;
          res_val_q  <= '0;
          if (col_q >= column_count_q) begin
            res_status_q <= ST_BAD_COL;
            state_q      <= S_RESP;
          end else if (len_clamped == '0) begin
            state_q <= S_MISS;
          end else begin
            state_q <= S_SRCH;
          end
        end
        S_SRCH: begin
          hit_val_q <= rd_val;
          if (rd_col >= col_q) begin
            state_q <= (rd_col == col_q) ? S_UPD : S_MISS;
          end else if (i_q + LW'(1) == len_q) begin
            i_q     <= len_q;
            state_q <= S_MISS;
          end else begin
            i_q <= i_q + LW'(1);
          end
        end
        S_UPD: begin
          res_status_q <= ST_UPDATED;
          res_slot_q   <= 4'(i_q);
          res_val_q    <= new_val;
          state_q      <= S_RESP;
        end
        S_MISS: begin
          if (no_new_q) begin
            res_status_q <= ST_NO_NEW;
            state_q      <= S_RESP;
          end else if (len_q == CAP_L) begin
            res_status_q <= ST_ROW_FULL;
            state_q      <= S_RESP;
          end else if (len_q == i_q) begin
            state_q <= S_INS;
          end else begin
            sh_j_q  <= len_q;
            state_q <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          sh_j_q <= sh_j_q - LW'(1);
          if (sh_j_q - LW'(1) == i_q) begin
            state_q <= S_INS;
          end
        end
        S_INS: begin
          total_q      <= total_q + TW'(1);
          res_status_q <= ST_INSERTED;
          res_slot_q   <= 4'(i_q);
          res_val_q    <= val_q;
          res_len_q    <= 5'(len_q + LW'(1));
          state_q      <= S_RESP;
        end
        S_RESP: begin
          // hold the result until the output register frees up
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_user_q  <= res_status_q;
            out_data_q  <= {4'd0, 11'(total_q), res_len_q, res_val_q, res_slot_q};
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // the shift never reads the slot it writes in the same cycle
  a_shift_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ent_we && ent_re) |-> (ent_waddr != ent_raddr))
    else $error("entry memory read and write collide");

  // an insert bumps the entry count by exactly one
  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS) |=> (total_q == $past(total_q) + TW'(1)))
    else $error("entry count did not advance on insert");

  // row lengths never exceed the row capacity once cleared
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LEN) |-> (len_rdata_q <= CAP_L))
    else $error("row length above capacity");

  // an inserted entry leaves a non-empty row
  a_ins_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ST_INSERTED)) |-> (m_axis_tdata[40:36] != 5'd0))
    else $error("insert reported an empty row");

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb - testbench for the sorted sparse row store
// Sends entry words through the input stream and keeps a shadow copy of the
// row store to work out each status word. Compares every result word field
// by field in arrival order. Both stream sides idle and stall at random, and
// the register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssri_pkg::*;

  localparam int unsigned MAX_ROWS      = 64;
  localparam int unsigned ROW_CAP       = 16;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  // The block is idle once the last result is out, so a short pause is enough.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_WORDS   = 180;

  // One expected result word, split into its fields.
  typedef struct {
    status_e     status;
    logic [3:0]  slot;
    logic [31:0] stored;
    logic [4:0]  row_len;
    logic [10:0] total;
  } entry_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  cfg_idx_t    cfg_idx_i;
  cfg_data_t   cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  in_data_t    s_axis_tdata;   // [15:0] row, [31:16] column, [63:32] value
  in_user_t    s_axis_tuser;   // [0] accumulate
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  out_data_t   m_axis_tdata;   // [3:0] slot, [35:4] stored_value,
                               // [40:36] row_length, [51:41] total_entries
  out_user_t   m_axis_tuser;   // [2:0] status

  // Shadow of the row store and of the registers, updated at each accepted word.
  logic [15:0]        shadow_cols [MAX_ROWS][ROW_CAP];
  logic signed [31:0] shadow_vals [MAX_ROWS][ROW_CAP];
  int unsigned        shadow_len  [MAX_ROWS];
  int unsigned        shadow_total;
  logic [6:0]         cur_row_count;
  logic [15:0]        cur_col_count;
  logic               cur_no_new;

  entry_result_t owed_results[$];   // results of accepted words, oldest first
  int unsigned   error_count;
  int unsigned   cycle_count;
  bit            steady_flow;       // set: no gaps and no stalls on either side

  sorted_sparse_row_insert #(
    .MAX_ROWS     (MAX_ROWS),
    .ROW_CAPACITY (ROW_CAP)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // Hard stop: a hung handshake must not run forever.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d results outstanding", $time,
               owed_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction: apply one entry word to the shadow store and return the result.
  // Row check comes first, then column check, then search for the first slot
  // whose column is not below the requested one.
  // ---------------------------------------------------------------------------
  function automatic entry_result_t apply_entry(logic [15:0] row, logic [15:0] col,
                                                logic signed [31:0] val, logic acc);
    entry_result_t res;
    int unsigned   len;
    int unsigned   pos;
    int unsigned   j;
    longint        sum;
    res.status  = ST_BAD_ROW;
    res.slot    = '0;
    res.stored  = '0;
    res.row_len = '0;
    res.total   = shadow_total[10:0];
    // Bad row: past the register limit or past the physical store.
    if (row >= cur_row_count || row >= MAX_ROWS) return res;
    len         = shadow_len[row];
    res.row_len = len[4:0];
    if (col >= cur_col_count) begin
      res.status = ST_BAD_COL;
      return res;
    end
    pos = 0;
    while (pos < len && shadow_cols[row][pos] < col) pos++;
    if (pos < len && shadow_cols[row][pos] == col) begin
      // Column present: overwrite, or add with clamp to the signed 32-bit range.
      if (acc) begin
        sum = longint'(shadow_vals[row][pos]) + longint'(val);
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        else if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        shadow_vals[row][pos] = sum[31:0];
      end else begin
        shadow_vals[row][pos] = val;
      end
      res.status = ST_UPDATED;
      res.slot   = pos[3:0];
      res.stored = shadow_vals[row][pos];
    end else if (cur_no_new) begin
      // No-new mode wins over a full row.
      res.status = ST_NO_NEW;
    end else if (len >= ROW_CAP) begin
      res.status = ST_ROW_FULL;
    end else begin
      // Move the later entries up one slot, then drop the new one in.
      for (j = len; j > pos; j--) begin
        shadow_cols[row][j] = shadow_cols[row][j-1];
        shadow_vals[row][j] = shadow_vals[row][j-1];
      end
      shadow_cols[row][pos] = col;
      shadow_vals[row][pos] = val;
      shadow_len[row]       = len + 1;
      shadow_total++;
      res.status  = ST_INSERTED;
      res.slot    = pos[3:0];
      res.stored  = val;
      res.row_len = shadow_len[row][4:0];
      res.total   = shadow_total[10:0];
    end
    return res;
  endfunction

  // Mostly no gap, some short, a few long.
  function automatic int unsigned draw_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Bias values toward the saturation edges now and then.
  function automatic logic [31:0] rand_value();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return {16'h7FFF, 16'($urandom)};
    if (pick < 30) return {16'h8000, 16'($urandom)};
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // Send one entry word. Valid stays high into the next word when no gap is
  // drawn, so it is never lowered and raised in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_word(logic [15:0] row, logic [15:0] col, logic [31:0] val,
                           logic acc);
    int unsigned gap;
    gap = steady_flow ? 0 : draw_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {val, col, row};
    s_axis_tuser  <= acc;
    do @(posedge clk_i); while (!s_axis_tready);
    owed_results.push_back(apply_entry(row, col, val, acc));
  endtask

  // Drop valid and hold until every outstanding result is out.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (owed_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; enable drops on the following edge.
  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_ROW_COUNT:    cur_row_count = data[6:0];
      CFG_COLUMN_COUNT: cur_col_count = data;
      CFG_NO_NEW:       cur_no_new    = data[0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [6:0] rows, logic [15:0] cols, logic no_new);
    write_reg(CFG_ROW_COUNT, {9'd0, rows});
    write_reg(CFG_COLUMN_COUNT, cols);
    write_reg(CFG_NO_NEW, {15'd0, no_new});
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked words: every status but row full, both saturation edges, field
  // extremes, and the register extremes including zero rows and zero columns.
  task automatic test_directed();
    set_config(7'd64, 16'hFFFF, 1'b0);
    send_word(16'd0, 16'd100, 32'h0001_0000, 1'b0);   // insert into an empty row
    send_word(16'd0, 16'd50, 32'h0002_8000, 1'b0);    // insert ahead, shift up
    send_word(16'd0, 16'd200, 32'hFFFF_0000, 1'b0);   // append at the end
    send_word(16'd0, 16'd100, 32'hFFFE_8000, 1'b0);   // overwrite
    send_word(16'd0, 16'd100, 32'h0000_4000, 1'b1);   // accumulate
    send_word(16'd0, 16'd0, 32'h7FFF_FFFF, 1'b0);     // lowest column goes to slot 0
    send_word(16'd0, 16'd0, 32'h7FFF_FFFF, 1'b1);     // clamp high
    send_word(16'd0, 16'd0, 32'h8000_0000, 1'b0);
    send_word(16'd0, 16'd0, 32'h8000_0000, 1'b1);     // clamp low
    send_word(16'd63, 16'hFFFE, 32'h1234_5678, 1'b1); // top row, top legal column
    send_word(16'd64, 16'd0, 32'h0000_0001, 1'b0);    // row past the store
    send_word(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1); // row is checked first
    send_word(16'd0, 16'hFFFF, 32'h0000_0001, 1'b0);  // column at the limit
    settle();
    // One row, one column.
    set_config(7'd1, 16'd1, 1'b0);
    send_word(16'd1, 16'd0, 32'h0000_0001, 1'b0);
    send_word(16'd0, 16'd1, 32'h0000_0001, 1'b0);
    send_word(16'd0, 16'd0, 32'h0003_0000, 1'b1);
    settle();
    // Zero rows and zero columns reject everything.
    set_config(7'd0, 16'd0, 1'b0);
    send_word(16'd0, 16'd0, 32'h0000_0001, 1'b0);
    settle();
    // Row limit above the store size: the store size still bounds the rows.
    set_config(7'd127, 16'hFFFF, 1'b0);
    send_word(16'd64, 16'd5, 32'h0000_0001, 1'b0);
    send_word(16'd63, 16'd1, 32'h0000_0002, 1'b0);
    settle();
    // No-new mode: absent column dropped, present column still updated.
    set_config(7'd64, 16'hFFFF, 1'b1);
    send_word(16'd0, 16'd7, 32'h0000_0001, 1'b0);
    send_word(16'd0, 16'd50, 32'h0001_0000, 1'b1);
    settle();
    set_config(7'd64, 16'd0, 1'b0);
    send_word(16'd0, 16'd0, 32'h0000_0001, 1'b0);
    settle();
  endtask

  // Fill a few rows past capacity with random columns, then hit them in
  // no-new mode with a mix of present and absent columns.
  task automatic test_fill_rows();
    logic [15:0] rows [6];
    logic [15:0] col;
    int unsigned k;
    set_config(7'd64, 16'hFFFF, 1'b0);
    foreach (rows[i]) rows[i] = 16'($urandom_range(0, MAX_ROWS - 1));
    foreach (rows[i]) begin
      repeat (ROW_CAP + 3)
        send_word(rows[i], 16'($urandom_range(0, 16'hFFFE)), rand_value(),
                  1'($urandom_range(0, 1)));
    end
    settle();
    set_config(7'd64, 16'hFFFF, 1'b1);
    repeat (36) begin
      k = $urandom_range(0, 5);
      if ($urandom_range(0, 1) && shadow_len[rows[k]] != 0)
        col = shadow_cols[rows[k]][$urandom_range(0, shadow_len[rows[k]] - 1)];
      else
        col = 16'($urandom_range(0, 16'hFFFE));
      send_word(rows[k], col, rand_value(), 1'($urandom_range(0, 1)));
    end
    settle();
  endtask

  // Bulk random traffic over several register settings. Most words land on a
  // few busy rows and a small column pool so rows fill and entries get hit
  // again; some go to other legal rows, and the rest are bad rows and bad columns.
  task automatic test_random_mix();
    int unsigned row_limits [6] = '{64, 40, 8, 8, 1, 64};
    int unsigned col_limits [6] = '{65535, 4096, 64, 64, 16, 20};
    bit          no_new_set [6] = '{0, 0, 0, 1, 0, 0};
    logic [15:0] busy_rows [6];
    logic [15:0] col_pool [24];
    logic [15:0] row;
    logic [15:0] col;
    int unsigned pick;
    for (int unsigned p = 0; p < 6; p++) begin
      set_config(row_limits[p][6:0], col_limits[p][15:0], no_new_set[p]);
      // Keep the pools when only the mode changes, so updates still find entries.
      if (p == 0 || row_limits[p] != row_limits[p-1] || col_limits[p] != col_limits[p-1]) begin
        foreach (busy_rows[i]) busy_rows[i] = 16'($urandom_range(0, row_limits[p] - 1));
        foreach (col_pool[i]) col_pool[i] = 16'($urandom_range(0, col_limits[p] - 1));
      end
      repeat (PHASE_WORDS) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          row = (pick < 65) ? busy_rows[$urandom_range(0, 5)]
                            : 16'($urandom_range(0, row_limits[p] - 1));
          col = col_pool[$urandom_range(0, 23)];
        end else if (pick < 90) begin
          row = 16'($urandom_range(row_limits[p], 16'hFFFF));
          col = 16'($urandom);
        end else begin
          row = 16'($urandom_range(0, row_limits[p] - 1));
          col = (col_limits[p] == 16'hFFFF) ? 16'hFFFF
                                            : 16'($urandom_range(col_limits[p], 16'hFFFF));
        end
        send_word(row, col, rand_value(), 1'($urandom_range(0, 1)));
      end
      settle();
    end
  endtask

  // Back-to-back words with the result side always ready.
  task automatic test_steady_flow();
    set_config(7'd64, 16'd300, 1'b0);
    steady_flow = 1'b1;
    repeat (120)
      send_word(16'($urandom_range(0, 15)), 16'($urandom_range(0, 319)), rand_value(),
                1'($urandom_range(0, 1)));
    settle();
    steady_flow = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready in bursts with random stalls between them.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned run_len;
    int unsigned stall_len;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      run_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                              : $urandom_range(1, 30);
      stall_len = draw_gap();
      m_axis_tready <= 1'b1;
      repeat (run_len) @(posedge clk_i);
      if (!steady_flow && stall_len != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall_len) @(posedge clk_i);
      end
    end
  end

  function automatic void compare_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (actv !== expv) begin
      error_count++;
      $display("%0t: %s mismatch: expected %h actual %h", $time, name, expv, actv);
    end
  endfunction

  // Check each result word against the oldest outstanding expectation.
  always @(posedge clk_i) begin : result_check
    entry_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (owed_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result word: expected none actual status %h data %h",
                 $time, m_axis_tuser, m_axis_tdata);
      end else begin
        want = owed_results.pop_front();
        compare_field("status", 32'(want.status), 32'(m_axis_tuser));
        compare_field("slot", 32'(want.slot), 32'(m_axis_tdata[3:0]));
        compare_field("stored_value", want.stored, m_axis_tdata[35:4]);
        compare_field("row_length", 32'(want.row_len), 32'(m_axis_tdata[40:36]));
        compare_field("total_entries", 32'(want.total), 32'(m_axis_tdata[51:41]));
        compare_field("tdata padding", '0, 32'(m_axis_tdata[55:52]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_ROW_COUNT;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    error_count   = 0;
    cycle_count   = 0;
    steady_flow   = 1'b0;
    shadow_total  = 0;
    foreach (shadow_len[r]) shadow_len[r] = 0;
    cur_row_count = 7'd64;
    cur_col_count = 16'hFFFF;
    cur_no_new    = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The clearing pass after reset holds tready low; send_word waits it out.
    test_directed();
    test_fill_rows();
    test_random_mix();
    test_steady_flow();

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
